@@ hdl/json_string_unescape_top_assert.svh @@
// Assertion macros used by the unescaper top level.
`ifndef JSON_STRING_UNESCAPE_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPE_TOP_ASSERT_SVH

// The condition must never hold while out of reset.
`define JSU_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) !(cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define JSU_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define JSU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/jsu_pkg.sv @@
// Shared types, constants and helper functions of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int unsigned MAX_OUT    = 512;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_OUT);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_QUOTE = 2'd1;
  localparam logic [1:0] KIND_NUL   = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // One request of up to three results, as queued between front and back.
  typedef struct packed {
    logic [1:0]                  kind;
    logic [1:0]                  cnt;
    logic [2:0][7:0]             data;
    logic [2:0][LEN_W-1:0]       len;
  } entry_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v < MAX_LEN) ? v + LEN_W'(1) : v;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    case (c)
      8'h6E:   v = 8'h0A;
      8'h74:   v = 8'h09;
      8'h72:   v = 8'h0D;
      8'h62:   v = 8'h08;
      8'h66:   v = 8'h0C;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/json_string_unescape_top.sv @@
// Top level of the streaming JSON string unescaper.
//   channel | direction | ports
//   in      | request   | in_valid, in_stall, in_byte
//   out     | result    | out_valid, out_stall, out_kind, out_data_byte, out_length, out_last
// One input byte is taken per cycle while the request queue has room.
// Each byte yields zero to three results; the output register sends one per cycle while out_stall is low,
// so a three-byte UTF-8 sequence holds the back end until all three bytes have gone out.
// The four-entry request queue absorbs those bursts; in_stall rises only when it is full.
// Reset is synchronous and active low and returns the block to waiting for a quote.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_top_assert.svh"

module json_string_unescape_top import jsu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_data_byte,
  output logic [LEN_W-1:0]       out_length,
  output logic                   out_last
);

  logic       fire, push, pop;
  entry_t     ent, head;
  fifo_stat_t stat;

  assign in_stall = stat.full;
  assign fire     = in_valid && !in_stall;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_byte),
    .push    (push),
    .ent     (ent)
  );

  jsu_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push && fire),
    .wr_ent (ent),
    .pop    (pop),
    .head   (head),
    .stat   (stat)
  );

  jsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_length    (out_length),
    .out_last      (out_last)
  );

  `JSU_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && fire && stat.full && !pop, "queue overflow")
  `JSU_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && stat.empty, "queue underflow")
  `JSU_ASSERT_IMPLY(a_len_sat, clk, rst_n, out_valid, out_length <= MAX_LEN, "length above limit")
  `JSU_ASSERT_IMPLY(a_end_form, clk, rst_n, out_valid && out_kind != KIND_DATA,
                    out_last && out_data_byte == 8'h00, "malformed end result")
  `JSU_ASSERT_NEXT(a_pop_count, clk, rst_n, pop && !(push && fire),
                   stat.count == $past(stat.count) - FIFO_CW'(1), "queue count slip")

endmodule

`default_nettype wire

@@ hdl/jsu_front.sv @@
// Front end: string state machine that turns the input bytes that yield results into result requests.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] in_byte,
  output logic            push,
  output entry_t          ent
);

  mode_t             mode_r, mode_nxt;
  logic [1:0]        hex_cnt_r, hex_cnt_nxt;
  logic [15:0]       cp_r, cp_nxt;
  logic [LEN_W-1:0]  bc_r, bc_nxt;

  logic [15:0]       cp_sh;
  logic [LEN_W-1:0]  len1, len2, len3;

  assign cp_sh = {cp_r[11:0], hex_value(in_byte)};
  assign len1  = sat_inc(bc_r);
  assign len2  = sat_inc(len1);
  assign len3  = sat_inc(len2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_cnt_r <= 2'd0;
      cp_r      <= 16'd0;
      bc_r      <= '0;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
      bc_r      <= bc_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_IDLE: begin
        if (in_byte == CH_QUOTE) mode_nxt = MODE_STR;
      end
      MODE_STR: begin
        if (in_byte == CH_NUL || in_byte == CH_QUOTE) mode_nxt = MODE_IDLE;
        else if (in_byte == CH_BSLASH) mode_nxt = MODE_ESC;
      end
      MODE_ESC: begin
        if (in_byte == CH_NUL) mode_nxt = MODE_IDLE;
        else if (in_byte == CH_U) mode_nxt = MODE_HEX;
        else mode_nxt = MODE_STR;
      end
      MODE_HEX: begin
        if (in_byte == CH_NUL) mode_nxt = MODE_IDLE;
        else if (hex_cnt_r == 2'd3) mode_nxt = MODE_STR;
      end
      default: mode_nxt = MODE_IDLE;
    endcase
  end

  always_comb begin
    ent         = '0;
    push        = 1'b0;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    bc_nxt      = bc_r;
    unique case (mode_r)
      MODE_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          bc_nxt      = '0;
          hex_cnt_nxt = 2'd0;
          cp_nxt      = 16'd0;
        end
      end
      MODE_STR: begin
        if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
          push        = 1'b1;
          ent.kind    = (in_byte == CH_NUL) ? KIND_NUL : KIND_QUOTE;
          ent.cnt     = 2'd1;
          ent.len[0]  = bc_r;
          hex_cnt_nxt = 2'd0;
          cp_nxt      = 16'd0;
        end else if (in_byte != CH_BSLASH) begin
          push        = 1'b1;
          ent.kind    = KIND_DATA;
          ent.cnt     = 2'd1;
          ent.data[0] = in_byte;
          ent.len[0]  = len1;
          bc_nxt      = len1;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_NUL) begin
          push        = 1'b1;
          ent.kind    = KIND_NUL;
          ent.cnt     = 2'd1;
          ent.len[0]  = bc_r;
          hex_cnt_nxt = 2'd0;
          cp_nxt      = 16'd0;
        end else if (in_byte == CH_U) begin
          hex_cnt_nxt = 2'd0;
          cp_nxt      = 16'd0;
        end else begin
          push        = 1'b1;
          ent.kind    = KIND_DATA;
          ent.cnt     = 2'd1;
          ent.data[0] = esc_map(in_byte);
          ent.len[0]  = len1;
          bc_nxt      = len1;
        end
      end
      MODE_HEX: begin
        if (in_byte == CH_NUL) begin
          push        = 1'b1;
          ent.kind    = KIND_NUL;
          ent.cnt     = 2'd1;
          ent.len[0]  = bc_r;
          hex_cnt_nxt = 2'd0;
          cp_nxt      = 16'd0;
        end else if (hex_cnt_r == 2'd3) begin
          push        = 1'b1;
          ent.kind    = KIND_DATA;
          hex_cnt_nxt = 2'd0;
          cp_nxt      = 16'd0;
          ent.len[0]  = len1;
          ent.len[1]  = len2;
          ent.len[2]  = len3;
          if (cp_sh < 16'h0080) begin
            ent.cnt     = 2'd1;
            ent.data[0] = cp_sh[7:0];
            bc_nxt      = len1;
          end else if (cp_sh < 16'h0800) begin
            ent.cnt     = 2'd2;
            ent.data[0] = {3'b110, cp_sh[10:6]};
            ent.data[1] = {2'b10, cp_sh[5:0]};
            bc_nxt      = len2;
          end else begin
            ent.cnt     = 2'd3;
            ent.data[0] = {4'b1110, cp_sh[15:12]};
            ent.data[1] = {2'b10, cp_sh[11:6]};
            ent.data[2] = {2'b10, cp_sh[5:0]};
            bc_nxt      = len3;
          end
        end else begin
          cp_nxt      = cp_sh;
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/jsu_fifo.sv @@
// Short request queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo import jsu_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t wr_ent,
  input  wire logic   pop,
  output entry_t      head,
  output fifo_stat_t  stat
);

  entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + FIFO_CW'(1);
    else if (pop && !push) count_nxt = count_r - FIFO_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_ent;
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

`default_nettype wire

@@ hdl/jsu_back.sv @@
// Back end: walks the results of each queued request into the output register.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire entry_t            head,
  input  wire fifo_stat_t        stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_data_byte,
  output logic [LEN_W-1:0]       out_length,
  output logic                   out_last
);

  logic              valid_r;
  logic [1:0]        slot_r;
  logic [1:0]        kind_r;
  logic [7:0]        data_r;
  logic [LEN_W-1:0]  len_r;
  logic              last_r;
  logic              adv, last_slot;

  // The output register is refilled whenever the queue holds a request and the register is empty or being taken.
  assign adv       = !stat.empty && (!valid_r || !out_stall);
  assign last_slot = (slot_r == head.cnt - 2'd1);
  assign pop       = adv && last_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= 2'd0;
    end else begin
      if (adv) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
      if (adv) slot_r <= last_slot ? 2'd0 : slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= head.kind;
      data_r <= head.data[slot_r];
      len_r  <= head.len[slot_r];
      last_r <= last_slot;
    end
  end

  assign out_valid     = valid_r;
  assign out_kind      = kind_r;
  assign out_data_byte = data_r;
  assign out_length    = len_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the streaming JSON string unescaper.
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  localparam int NDIR       = 25;
  localparam int RAND_ITEMS = 395;
  localparam int DRAIN      = 30;
  localparam int LIMIT      = 200000;

  // One text byte; typed rows carry their expected result in the table.
  typedef struct packed {
    logic [7:0]       b;
    logic             typed;
    logic             has_res;
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } stim_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             last;
  } result_t;

  localparam stim_t DIR_TAB [NDIR] = '{
    '{8'h41,     1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},  // ignored while idle
    '{CH_NUL,    1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_QUOTE,  1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_NUL,    1'b1, 1'b1, KIND_NUL,  8'h00, 10'd0},
    '{CH_QUOTE,  1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{8'hFF,     1'b1, 1'b1, KIND_DATA, 8'hFF, 10'd1},
    '{CH_BSLASH, 1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{"n",       1'b1, 1'b1, KIND_DATA, 8'h0A, 10'd2},
    '{CH_BSLASH, 1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_QUOTE,  1'b1, 1'b1, KIND_DATA, 8'h22, 10'd3},
    '{CH_BSLASH, 1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_U,      1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{"F",       1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{"f",       1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_QUOTE,  1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},  // a quote among hex digits is zero
    '{"a",       1'b0, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_QUOTE,  1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_BSLASH, 1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_NUL,    1'b1, 1'b1, KIND_NUL,  8'h00, 10'd0},
    '{CH_QUOTE,  1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_BSLASH, 1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_U,      1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{"1",       1'b1, 1'b0, KIND_DATA, 8'h00, 10'd0},
    '{CH_NUL,    1'b1, 1'b1, KIND_NUL,  8'h00, 10'd0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_byte;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_kind;
  logic [7:0]       out_data_byte;
  logic [LEN_W-1:0] out_length;
  logic             out_last;

  stim_t   text_q[$];
  result_t step_res[$];
  result_t expected_q[$];
  int      sent_idx;
  int      errors;
  int      cycles;
  int      idle_pct;
  int      stall_pct;

  // Unescaper state as the predictor sees it.
  mode_t            st_mode;
  logic [1:0]       hex_n;
  logic [15:0]      cp_acc;
  logic [LEN_W-1:0] str_len;

  json_string_unescape_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_data_byte(out_data_byte),
    .out_length   (out_length),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Returns {valid, value}; a non-hex byte has value zero.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void push_data(input logic [7:0] d);
    if (str_len < MAX_LEN) str_len++;
    step_res.push_back('{KIND_DATA, d, str_len, 1'b0});
  endfunction

  function automatic void close_str(input logic [1:0] kind);
    step_res.push_back('{kind, 8'h00, str_len, 1'b0});
    st_mode = MODE_IDLE;
    hex_n   = '0;
    cp_acc  = '0;
  endfunction

  function automatic void push_utf8(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      push_data(cp[7:0]);
    end else if (cp < 16'h0800) begin
      push_data(8'hC0 | 8'(cp[10:6]));
      push_data(8'h80 | 8'(cp[5:0]));
    end else begin
      push_data(8'hE0 | 8'(cp[15:12]));
      push_data(8'h80 | 8'(cp[11:6]));
      push_data(8'h80 | 8'(cp[5:0]));
    end
  endfunction

  // Advances the predictor by one text byte and leaves its results in step_res.
  function automatic void unescape_step(input logic [7:0] c);
    result_t    r;
    logic [4:0] h;
    logic [7:0] v;
    step_res.delete();
    case (st_mode)
      MODE_IDLE: begin
        if (c == CH_QUOTE) begin
          st_mode = MODE_STR;
          str_len = '0;
          hex_n   = '0;
          cp_acc  = '0;
        end
      end
      MODE_STR: begin
        if (c == CH_NUL) close_str(KIND_NUL);
        else if (c == CH_QUOTE) close_str(KIND_QUOTE);
        else if (c == CH_BSLASH) st_mode = MODE_ESC;
        else push_data(c);
      end
      MODE_ESC: begin
        if (c == CH_NUL) begin
          close_str(KIND_NUL);
        end else if (c == CH_U) begin
          st_mode = MODE_HEX;
          hex_n   = '0;
          cp_acc  = '0;
        end else begin
          case (c)
            "n":     v = 8'h0A;
            "t":     v = 8'h09;
            "r":     v = 8'h0D;
            "b":     v = 8'h08;
            "f":     v = 8'h0C;
            default: v = c;
          endcase
          push_data(v);
          st_mode = MODE_STR;
        end
      end
      default: begin
        if (c == CH_NUL) begin
          close_str(KIND_NUL);
        end else begin
          h      = hex_of(c);
          cp_acc = {cp_acc[11:0], h[3:0]};
          if (hex_n == 2'd3) begin
            push_utf8(cp_acc);
            hex_n   = '0;
            cp_acc  = '0;
            st_mode = MODE_STR;
          end else begin
            hex_n++;
          end
        end
      end
    endcase
    if (step_res.size() > 0) begin
      r      = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
  endfunction

  function automatic void put(input logic [7:0] b);
    text_q.push_back('{b, 1'b0, 1'b0, KIND_DATA, 8'h00, {LEN_W{1'b0}}});
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic void gen_unicode();
    logic [15:0] cp;
    logic [3:0]  v;
    logic [7:0]  ch;
    logic [4:0]  h;
    put(CH_BSLASH);
    put(CH_U);
    case ($urandom_range(2))
      0:       cp = 16'($urandom_range(0, 16'h007F));
      1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
      default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
    for (int i = 3; i >= 0; i--) begin
      v = cp[i*4 +: 4];
      if (v == 4'd0 && $urandom_range(3) == 0) begin
        // Any non-hex byte stands for a zero digit.
        do begin
          ch = 8'($urandom_range(1, 255));
          h  = hex_of(ch);
        end while (h[4]);
      end else if (v < 4'd10) begin
        ch = 8'("0" + v);
      end else begin
        ch = 8'(($urandom_range(1) ? "A" : "a") + v - 4'd10);
      end
      put(ch);
    end
  endfunction

  function automatic void gen_string();
    int         ntok;
    int         t;
    logic [7:0] ch;
    put(CH_QUOTE);
    ntok = $urandom_range(0, 10);
    for (int k = 0; k < ntok; k++) begin
      t = $urandom_range(99);
      if (t < 55) begin
        put(plain_char());
      end else if (t < 75) begin
        put(CH_BSLASH);
        case ($urandom_range(8))
          0: put("n");
          1: put("t");
          2: put("r");
          3: put("b");
          4: put("f");
          5: put(CH_QUOTE);
          6: put(CH_BSLASH);
          7: put("/");
          default: begin
            do ch = 8'($urandom_range(1, 255)); while (ch == CH_U);
            put(ch);
          end
        endcase
      end else if (t < 95) begin
        gen_unicode();
      end else begin
        // Broken strings: a NUL cuts them anywhere.
        case ($urandom_range(2))
          0: put(CH_NUL);
          1: begin
            put(CH_BSLASH);
            put(CH_NUL);
          end
          default: begin
            put(CH_BSLASH);
            put(CH_U);
            repeat ($urandom_range(0, 3)) put(plain_char());
            put(CH_NUL);
          end
        endcase
        return;
      end
    end
    put(($urandom_range(5) == 0) ? CH_NUL : CH_QUOTE);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    stim_t   it;
    result_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        it = text_q[sent_idx];
        unescape_step(it.b);
        if (it.typed) begin
          if (it.has_res) expected_q.push_back('{it.kind, it.data, it.len, 1'b1});
        end else begin
          foreach (step_res[i]) expected_q.push_back(step_res[i]);
        end
        sent_idx++;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t ERROR unexpected result kind=%0d data=0x%0h length=%0d last=%0b",
                   $time, out_kind, out_data_byte, out_length, out_last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("data_byte", 16'(want.data), 16'(out_data_byte));
          check_field("length", 16'(want.len), 16'(out_length));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
      case ((sent_idx * 8 / text_q.size()) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      if (!in_valid || !in_stall) begin
        if (sent_idx < text_q.size() && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= text_q[sent_idx].b;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int target;
    int n0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    out_stall = 1'b0;
    sent_idx  = 0;
    errors    = 0;
    cycles    = 0;
    idle_pct  = 0;
    stall_pct = 0;
    st_mode   = MODE_IDLE;
    hex_n     = '0;
    cp_acc    = '0;
    str_len   = '0;

    foreach (DIR_TAB[i]) text_q.push_back(DIR_TAB[i]);
    target = text_q.size() + RAND_ITEMS;
    while (text_q.size() < target) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 4)) begin
          n0 = $urandom_range(0, 255);
          put((8'(n0) == CH_QUOTE) ? 8'h21 : 8'(n0));
        end
      end else begin
        gen_string();
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_idx < text_q.size()) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
